FILE: hw/rtl/hdlc_frame_receiver_core_assert.svh
// ----------------------------------------------------------------------------
// hdlc frame receiver assertion macros
// implication checks used by the receiver modules, removed with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef HDLC_FRAME_RECEIVER_CORE_ASSERT_SVH
`define HDLC_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define HFR_ASSERT_IMP(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
    else $error("hfr assertion failed");
`define HFR_ASSERT_NEXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
    else $error("hfr assertion failed");
`else
`define HFR_ASSERT_IMP(lbl, ck, rn, a, b)
`define HFR_ASSERT_NEXT(lbl, ck, rn, a, b)
`endif
`endif

FILE: hw/rtl/hfr_pkg.sv
// ----------------------------------------------------------------------------
// hfr_pkg
// constants, result type and crc-16 byte update for the hdlc frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package hfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 10;
  localparam int unsigned CrcW   = 16;

  localparam logic [ByteW-1:0]  FLAG_BYTE = 8'h7E;
  localparam logic [ByteW-1:0]  ESC_BYTE  = 8'h7D;
  localparam logic [ByteW-1:0]  ESC_XOR   = 8'h20;
  localparam logic [CrcW-1:0]   CRC_INIT  = 16'hFFFF;
  localparam logic [CrcW-1:0]   CRC_POLY  = 16'h8408;
  localparam logic [CrcW-1:0]   CRC_GOOD  = 16'hF0B8;
  localparam logic [CountW-1:0] MAX_FRAME_RESET = 10'd256;
  localparam logic [CountW-1:0] MIN_CLOSE_COUNT = 10'd2;
  localparam logic [CountW-1:0] FCS_BYTES       = 10'd2;

  typedef struct packed {
    logic              data_valid;
    logic [ByteW-1:0]  data_byte;
    logic [CountW-1:0] data_index;
    logic              frame_end;
    logic              frame_good;
    logic [CountW-1:0] body_length;
    logic              frame_dropped;
  } result_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hfr_decode.sv
// ----------------------------------------------------------------------------
// hfr_decode
// frame state, escape removal, crc check and size limit for one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

`include "hdlc_frame_receiver_core_assert.svh"

module hfr_decode (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [hfr_pkg::ByteW-1:0]   rx_byte,
  input  wire logic [hfr_pkg::CountW-1:0]  max_frame_bytes,
  output hfr_pkg::result_t                 res
);

  logic                        in_frame_r, in_frame_nxt;
  logic                        esc_r, esc_nxt;
  logic [hfr_pkg::CountW-1:0]  count_r, count_nxt;
  logic [hfr_pkg::CrcW-1:0]    crc_r, crc_nxt;
  logic [hfr_pkg::ByteW-1:0]   byte_val;
  logic [hfr_pkg::CountW-1:0]  count_inc;

  assign byte_val  = esc_r ? (rx_byte ^ hfr_pkg::ESC_XOR) : rx_byte;
  assign count_inc = count_r + hfr_pkg::CountW'(1);

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    res          = '0;
    if (!in_frame_r) begin
      if (rx_byte == hfr_pkg::FLAG_BYTE) begin
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        count_nxt    = '0;
        crc_nxt      = hfr_pkg::CRC_INIT;
      end
    end else if (rx_byte == hfr_pkg::FLAG_BYTE) begin
      if (count_r > hfr_pkg::MIN_CLOSE_COUNT) begin
        res.frame_end = 1'b1;
        if (crc_r == hfr_pkg::CRC_GOOD) begin
          res.frame_good  = 1'b1;
          res.body_length = count_r - hfr_pkg::FCS_BYTES;
        end
        in_frame_nxt = 1'b0;
      end else begin
        in_frame_nxt = 1'b1;
      end
      esc_nxt   = 1'b0;
      count_nxt = '0;
      crc_nxt   = hfr_pkg::CRC_INIT;
    end else if (rx_byte == hfr_pkg::ESC_BYTE) begin
      esc_nxt = 1'b1;
    end else begin
      res.data_valid = 1'b1;
      res.data_byte  = byte_val;
      res.data_index = count_r;
      esc_nxt        = 1'b0;
      crc_nxt        = hfr_pkg::crc_update(crc_r, byte_val);
      count_nxt      = count_inc;
      if (count_inc >= max_frame_bytes) begin
        res.frame_dropped = 1'b1;
        in_frame_nxt      = 1'b0;
        count_nxt         = '0;
        crc_nxt           = hfr_pkg::CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      count_r    <= '0;
      crc_r      <= hfr_pkg::CRC_INIT;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
    end
  end

  `HFR_ASSERT_IMP(a_drop_has_data, clk, rst_n, step && res.frame_dropped, res.data_valid)
  `HFR_ASSERT_IMP(a_end_no_data, clk, rst_n, step && res.frame_end, !res.data_valid)
  `HFR_ASSERT_IMP(a_good_needs_end, clk, rst_n, res.frame_good, res.frame_end)
  `HFR_ASSERT_NEXT(a_end_hunts, clk, rst_n, step && (res.frame_end || res.frame_dropped),
                   !in_frame_r && (count_r == '0) && (crc_r == hfr_pkg::CRC_INIT))

endmodule

`default_nettype wire

FILE: hw/rtl/hdlc_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_core
// hdlc / ppp byte deframer with escape removal and crc-16 fcs check
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid/in_ready carries one raw line byte (in_rx_byte)
// - output channel out_valid/out_ready carries exactly one result per input
//   transfer: stored byte with index (with the drop flag when it reaches the
//   size limit), frame end with good flag and payload length, or an empty one
// - cfg_wr_en/cfg_wr_data write max_frame_bytes (reset 256), only while idle
// - path: input register, then result register, with the decode and crc update
//   combinational between them
// - throughput: one byte per cycle while out_ready is high, set by the
//   byte-wide crc update that runs in the decode stage
// - reset: both registers empty, hunting for a flag, crc at 0xffff
// - with out_ready low and a result waiting, the result register holds and the
//   input register still takes one more byte; in_ready drops once both are full
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_frame_receiver_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [hfr_pkg::ByteW-1:0]   in_rx_byte,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        out_data_valid,
  output      logic [hfr_pkg::ByteW-1:0]   out_data_byte,
  output      logic [hfr_pkg::CountW-1:0]  out_data_index,
  output      logic                        out_frame_end,
  output      logic                        out_frame_good,
  output      logic [hfr_pkg::CountW-1:0]  out_body_length,
  output      logic                        out_frame_dropped,
  input  wire logic                        cfg_wr_en,
  input  wire logic [hfr_pkg::CountW-1:0]  cfg_wr_data
);

  logic                        in_valid_r;
  logic [hfr_pkg::ByteW-1:0]   in_byte_r;
  logic                        out_valid_r;
  hfr_pkg::result_t            out_r;
  hfr_pkg::result_t            res;
  logic [hfr_pkg::CountW-1:0]  max_frame_r;
  logic                        advance;
  logic                        step;

  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= hfr_pkg::MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      max_frame_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  hfr_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .rx_byte         (in_byte_r),
    .max_frame_bytes (max_frame_r),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_valid    = out_r.data_valid;
  assign out_data_byte     = out_r.data_byte;
  assign out_data_index    = out_r.data_index;
  assign out_frame_end     = out_r.frame_end;
  assign out_frame_good    = out_r.frame_good;
  assign out_body_length   = out_r.body_length;
  assign out_frame_dropped = out_r.frame_dropped;

endmodule

`default_nettype wire

FILE: bench/hdlc_frame_receiver_core_checker.sv
// ----------------------------------------------------------------------------
// hdlc frame receiver result checker
// follows every byte transfer on the input channel with its own deframer
// model (flag hunt, escape removal, fcs-16 residue, size limit) and compares
// each output transfer against the oldest predicted result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hdlc_frame_receiver_core_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [hfr_pkg::ByteW-1:0]  in_rx_byte,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_data_valid,
  input  logic [hfr_pkg::ByteW-1:0]  out_data_byte,
  input  logic [hfr_pkg::CountW-1:0] out_data_index,
  input  logic                       out_frame_end,
  input  logic                       out_frame_good,
  input  logic [hfr_pkg::CountW-1:0] out_body_length,
  input  logic                       out_frame_dropped,
  input  logic                       cfg_wr_en,
  input  logic [hfr_pkg::CountW-1:0] cfg_wr_data,
  output int unsigned                mismatches,
  output int unsigned                outstanding
);

  logic                       in_frame;
  logic                       esc_pending;
  logic [hfr_pkg::CountW-1:0] stored_count;
  logic [hfr_pkg::CrcW-1:0]   fcs_acc;
  logic [hfr_pkg::CountW-1:0] frame_limit;
  hfr_pkg::result_t           pending_results[$];
  int unsigned                bad_seen;

  function automatic logic [hfr_pkg::CrcW-1:0] fcs_fold(
      input logic [hfr_pkg::CrcW-1:0] acc, input logic [hfr_pkg::ByteW-1:0] b);
    logic [hfr_pkg::CrcW-1:0] r;
    logic                     fb;
    r = acc;
    for (int i = 0; i < hfr_pkg::ByteW; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ hfr_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void clear_frame(input logic stay);
    in_frame     = stay;
    esc_pending  = 1'b0;
    stored_count = '0;
    fcs_acc      = hfr_pkg::CRC_INIT;
  endfunction

  function automatic hfr_pkg::result_t decode_line_byte(input logic [hfr_pkg::ByteW-1:0] b);
    hfr_pkg::result_t          r;
    logic [hfr_pkg::ByteW-1:0] v;
    r = '0;
    if (!in_frame) begin
      if (b == hfr_pkg::FLAG_BYTE) begin
        clear_frame(1'b1);
      end
    end else if (b == hfr_pkg::FLAG_BYTE) begin
      if (stored_count > hfr_pkg::MIN_CLOSE_COUNT) begin
        r.frame_end = 1'b1;
        if (fcs_acc == hfr_pkg::CRC_GOOD) begin
          r.frame_good  = 1'b1;
          r.body_length = stored_count - hfr_pkg::FCS_BYTES;
        end
        clear_frame(1'b0);
      end else begin
        clear_frame(1'b1);
      end
    end else if (b == hfr_pkg::ESC_BYTE) begin
      esc_pending = 1'b1;
    end else begin
      v = esc_pending ? (b ^ hfr_pkg::ESC_XOR) : b;
      esc_pending  = 1'b0;
      r.data_valid = 1'b1;
      r.data_byte  = v;
      r.data_index = stored_count;
      fcs_acc      = fcs_fold(fcs_acc, v);
      stored_count = stored_count + hfr_pkg::CountW'(1);
      if (stored_count >= frame_limit) begin
        r.frame_dropped = 1'b1;
        clear_frame(1'b0);
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input hfr_pkg::result_t e,
                               input hfr_pkg::result_t a);
    bad_seen++;
    if (bad_seen <= 10) begin
      $display("%0t mismatch (%s)", $time, what);
      $display("  expected dv=%0d byte=%02h idx=%0d end=%0d good=%0d len=%0d drop=%0d",
               e.data_valid, e.data_byte, e.data_index, e.frame_end, e.frame_good,
               e.body_length, e.frame_dropped);
      $display("  actual   dv=%0d byte=%02h idx=%0d end=%0d good=%0d len=%0d drop=%0d",
               a.data_valid, a.data_byte, a.data_index, a.frame_end, a.frame_good,
               a.body_length, a.frame_dropped);
    end
  endtask

  always @(posedge clk) begin : watch
    hfr_pkg::result_t got;
    hfr_pkg::result_t want;
    if (!rst_n) begin
      clear_frame(1'b0);
      frame_limit = hfr_pkg::MAX_FRAME_RESET;
      pending_results.delete();
      bad_seen = 0;
    end else begin
      if (cfg_wr_en) begin
        frame_limit = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        got.data_valid    = out_data_valid;
        got.data_byte     = out_data_byte;
        got.data_index    = out_data_index;
        got.frame_end     = out_frame_end;
        got.frame_good    = out_frame_good;
        got.body_length   = out_body_length;
        got.frame_dropped = out_frame_dropped;
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
              got.data_index !== want.data_index || got.frame_end !== want.frame_end ||
              got.frame_good !== want.frame_good ||
              got.body_length !== want.body_length ||
              got.frame_dropped !== want.frame_dropped) begin
            note_mismatch("field differs", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(decode_line_byte(in_rx_byte));
      end
    end
    mismatches  <= bad_seen;
    outstanding <= pending_results.size();
  end

endmodule

FILE: bench/hdlc_frame_receiver_core_test.sv
// ----------------------------------------------------------------------------
// hdlc frame receiver testbench
// drives line bytes into the deframer: directed flag and escape corner
// cases, then random good, corrupted, truncated and aborted frames under
// several frame size limits, with random idling on both channels and a
// long output hold-off; the checker predicts and compares every transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hdlc_frame_receiver_core_test;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic [hfr_pkg::ByteW-1:0]  in_rx_byte  = '0;
  logic                       out_ready   = 1'b0;
  logic                       cfg_wr_en   = 1'b0;
  logic [hfr_pkg::CountW-1:0] cfg_wr_data = '0;

  logic                       in_ready;
  logic                       out_valid;
  logic                       out_data_valid;
  logic [hfr_pkg::ByteW-1:0]  out_data_byte;
  logic [hfr_pkg::CountW-1:0] out_data_index;
  logic                       out_frame_end;
  logic                       out_frame_good;
  logic [hfr_pkg::CountW-1:0] out_body_length;
  logic                       out_frame_dropped;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned line_bytes = 0;
  logic        idle_on    = 1'b1;
  logic        hold_phase = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hdlc_frame_receiver_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_valid    (out_data_valid),
    .out_data_byte     (out_data_byte),
    .out_data_index    (out_data_index),
    .out_frame_end     (out_frame_end),
    .out_frame_good    (out_frame_good),
    .out_body_length   (out_body_length),
    .out_frame_dropped (out_frame_dropped),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  hdlc_frame_receiver_core_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_valid    (out_data_valid),
    .out_data_byte     (out_data_byte),
    .out_data_index    (out_data_index),
    .out_frame_end     (out_frame_end),
    .out_frame_good    (out_frame_good),
    .out_body_length   (out_body_length),
    .out_frame_dropped (out_frame_dropped),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  // result side: random stalls while idling is on, and repeated long stalls in the hold phase
  initial begin : result_side
    int unsigned phase_cyc;
    phase_cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_phase && (phase_cyc % 400) < 250) begin
        out_ready <= 1'b0;
      end else if (idle_on) begin
        out_ready <= ($urandom_range(99) >= 20);
      end else begin
        out_ready <= 1'b1;
      end
      phase_cyc = hold_phase ? phase_cyc + 1 : 0;
    end
  end

  task automatic offer_byte(input logic [hfr_pkg::ByteW-1:0] b);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    line_bytes++;
  endtask

  function automatic logic [hfr_pkg::ByteW-1:0] line_pick();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) begin
      return hfr_pkg::FLAG_BYTE;
    end else if (r < 24) begin
      return hfr_pkg::ESC_BYTE;
    end
    return hfr_pkg::ByteW'($urandom_range(255));
  endfunction

  // opening flag, escaped payload plus fcs, closing flag
  task automatic offer_frame(input logic [hfr_pkg::ByteW-1:0] payload[$], input bit spoil);
    logic [hfr_pkg::ByteW-1:0] line[$];
    logic [hfr_pkg::CrcW-1:0]  fcs;
    logic [hfr_pkg::ByteW-1:0] alt;
    int unsigned               k;
    line = payload;
    fcs  = hfr_pkg::CRC_INIT;
    foreach (payload[i]) begin
      fcs = hfr_pkg::crc_update(fcs, payload[i]);
    end
    fcs = ~fcs;
    line.push_back(fcs[7:0]);
    line.push_back(fcs[15:8]);
    if (spoil) begin
      k = $urandom_range(line.size() - 1);
      line[k] = line[k] ^ (8'h01 << $urandom_range(7));
    end
    offer_byte(hfr_pkg::FLAG_BYTE);
    foreach (line[i]) begin
      alt = line[i] ^ hfr_pkg::ESC_XOR;
      if (line[i] == hfr_pkg::FLAG_BYTE || line[i] == hfr_pkg::ESC_BYTE ||
          (alt != hfr_pkg::FLAG_BYTE && alt != hfr_pkg::ESC_BYTE &&
           $urandom_range(99) < 8)) begin
        offer_byte(hfr_pkg::ESC_BYTE);
        offer_byte(alt);
      end else begin
        offer_byte(line[i]);
      end
    end
    offer_byte(hfr_pkg::FLAG_BYTE);
  endtask

  task automatic offer_payload(input int unsigned len, input bit spoil);
    logic [hfr_pkg::ByteW-1:0] payload[$];
    repeat (len) begin
      payload.push_back(line_pick());
    end
    offer_frame(payload, spoil);
  endtask

  task automatic mixed_traffic(input int unsigned target, input int unsigned max_len);
    int unsigned stop;
    int unsigned r;
    stop = line_bytes + target;
    while (line_bytes < stop) begin
      r = $urandom_range(99);
      if (r < 60) begin
        offer_payload($urandom_range(max_len), 1'b0);
      end else if (r < 72) begin
        offer_payload($urandom_range(max_len), 1'b1);
      end else if (r < 82) begin
        // truncated frame, the next flag closes it
        offer_byte(hfr_pkg::FLAG_BYTE);
        repeat ($urandom_range(1, 8)) begin
          offer_byte(line_pick());
        end
      end else if (r < 90) begin
        // escape right before a flag
        offer_byte(hfr_pkg::FLAG_BYTE);
        repeat ($urandom_range(0, 5)) begin
          offer_byte(hfr_pkg::ByteW'($urandom_range(8'h7C)));
        end
        offer_byte(hfr_pkg::ESC_BYTE);
        offer_byte(hfr_pkg::FLAG_BYTE);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          offer_byte(line_pick());
        end
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_limit(input logic [hfr_pkg::CountW-1:0] limit);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [hfr_pkg::ByteW-1:0] seq[$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored while hunting, then a short flag restart
    seq = '{8'h00, 8'hFF, hfr_pkg::FLAG_BYTE, 8'h11, hfr_pkg::FLAG_BYTE};
    foreach (seq[i]) begin
      offer_byte(seq[i]);
    end
    // good frame carrying flag and escape values
    seq = '{hfr_pkg::FLAG_BYTE, hfr_pkg::ESC_BYTE, 8'h00, 8'hFF};
    offer_frame(seq, 1'b0);
    // double escape, then escape discarded by the closing flag
    seq = '{hfr_pkg::FLAG_BYTE, hfr_pkg::ESC_BYTE, hfr_pkg::ESC_BYTE, 8'h41, 8'h42, 8'h43,
            hfr_pkg::ESC_BYTE, hfr_pkg::FLAG_BYTE};
    foreach (seq[i]) begin
      offer_byte(seq[i]);
    end

    write_frame_limit(10'd3);
    mixed_traffic(120, 8);

    write_frame_limit(10'd1023);
    offer_payload(250, 1'b0);
    mixed_traffic(100, 24);

    write_frame_limit(hfr_pkg::CountW'($urandom_range(4, 40)));
    hold_phase <= 1'b1;
    mixed_traffic(250, 24);
    hold_phase <= 1'b0;

    write_frame_limit(hfr_pkg::MAX_FRAME_RESET);
    idle_on <= 1'b0;
    mixed_traffic(200, 24);
    idle_on <= 1'b1;
    mixed_traffic(100, 24);

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("[hdlc_frame_receiver_core] OK");
    end else begin
      $display("[hdlc_frame_receiver_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("[hdlc_frame_receiver_core] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hfr_pkg.sv
hw/rtl/hfr_decode.sv
hw/rtl/hdlc_frame_receiver_core.sv
bench/hdlc_frame_receiver_core_checker.sv
bench/hdlc_frame_receiver_core_test.sv
